// ===== design/gcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// gcsg_pkg
// Shared constants for the gap cluster same-group query block.
// ----------------------------------------------------------------------------
package gcsg_pkg;

  localparam int POS_W = 32;
  localparam int QIDX_W = 10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ANS_DIFF = 2'd0;
  localparam logic [1:0] ANS_SAME = 2'd1;
  localparam logic [1:0] ANS_BAD  = 2'd2;

endpackage

// ===== design/gcsg_label_mem.sv =====
// ----------------------------------------------------------------------------
// gcsg_label_mem
// Group label memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gcsg_label_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gcsg_sorter.sv =====
// ----------------------------------------------------------------------------
// gcsg_sorter
// Point memory with in-place stable insertion sort and a labeling sweep.
// ----------------------------------------------------------------------------
module gcsg_sorter #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ld_we,
  input  logic [AW-1:0]           ld_addr,
  input  logic [gcsg_pkg::POS_W-1:0] ld_pos,
  input  logic                    start,
  input  logic [CW-1:0]           count,
  input  logic [gcsg_pkg::POS_W-1:0] gap_limit,
  output logic                    done,
  output logic                    lbl_we,
  output logic [AW-1:0]           lbl_addr,
  output logic [AW-1:0]           lbl_data
);

  localparam int PW = gcsg_pkg::POS_W;
  localparam int EW = PW + AW;

  typedef enum logic [7:0] {
    SS_IDLE  = 8'b0000_0001,
    SS_FETCH = 8'b0000_0010,
    SS_CUR   = 8'b0000_0100,
    SS_CMP   = 8'b0000_1000,
    SS_PLACE = 8'b0001_0000,
    SS_NEXT  = 8'b0010_0000,
    SS_GFET  = 8'b0100_0000,
    SS_GRUN  = 8'b1000_0000
  } sort_state_t;

  // Entry: load index above, position in the low bits.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic [AW-1:0] ra;

  sort_state_t   st_r, st_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] lab_r, lab_nxt;
  logic [AW-1:0] lab_new;
  logic [PW-1:0] gap;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  assign gap = rd[PW-1:0] - prev_r;

  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    lab_nxt  = lab_r;
    we       = 1'b0;
    wa       = j_r;
    wd       = cur_r;
    ra       = i_r;
    done     = 1'b0;
    lbl_we   = 1'b0;
    lbl_addr = rd[EW-1:PW];
    lab_new  = lab_r;
    if (j_r != '0 && gap > gap_limit) begin
      lab_new = lab_r + AW'(1);
    end
    lbl_data = lab_new;
    unique case (st_r)
      SS_IDLE: begin
        if (ld_we) begin
          we = 1'b1;
          wa = ld_addr;
          wd = {ld_addr, ld_pos};
        end
        if (start) begin
          i_nxt  = '0;
          st_nxt = SS_FETCH;
        end
      end
      SS_FETCH: begin
        st_nxt = SS_CUR;
      end
      SS_CUR: begin
        cur_nxt = rd;
        if (i_r == '0) begin
          st_nxt = SS_NEXT;
        end else begin
          j_nxt  = i_r;
          ra     = i_r - AW'(1);
          st_nxt = SS_CMP;
        end
      end
      SS_CMP: begin
        we = 1'b1;
        if (rd[PW-1:0] > cur_r[PW-1:0]) begin
          // Shift the larger entry up one place and keep walking down.
          wd    = rd;
          j_nxt = j_r - AW'(1);
          ra    = j_r - AW'(2);
          if (j_r == AW'(1)) begin
            st_nxt = SS_PLACE;
          end
        end else begin
          st_nxt = SS_NEXT;
        end
      end
      SS_PLACE: begin
        we     = 1'b1;
        st_nxt = SS_NEXT;
      end
      SS_NEXT: begin
        if (CW'(i_r) + CW'(1) == count) begin
          j_nxt   = '0;
          ra      = '0;
          lab_nxt = '0;
          st_nxt  = SS_GFET;
        end else begin
          i_nxt  = i_r + AW'(1);
          st_nxt = SS_FETCH;
        end
      end
      SS_GFET: begin
        ra     = j_r;
        st_nxt = SS_GRUN;
      end
      SS_GRUN: begin
        // j_r walks the sorted list here.
        lbl_we   = 1'b1;
        lab_nxt  = lab_new;
        prev_nxt = rd[PW-1:0];
        if (CW'(j_r) + CW'(1) == count) begin
          done   = 1'b1;
          st_nxt = SS_IDLE;
        end else begin
          j_nxt = j_r + AW'(1);
          ra    = j_r + AW'(1);
        end
      end
      default: st_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    lab_r  <= lab_nxt;
  end

endmodule

// ===== design/gap_cluster_same_group_query.sv =====
// ----------------------------------------------------------------------------
// gap_cluster_same_group_query
// One-dimensional gap clustering of loaded points with same-group queries.
// ----------------------------------------------------------------------------
// A query reads both labels from the label memory in turn, then registers the
// answer. The load with tlast starts a sort-and-label pass over the point
// memory: an in-place insertion sort that moves each entry down past every
// larger one, then the labeling sweep over the sorted list; no item is taken
// during that pass. Configuration may be written at any time the block is idle
// and is always ready.
module gap_cluster_same_group_query #(
  parameter int MAX_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // position[31:0], first_index[41:32], second_index[51:42]
  input  logic        in_tuser,  // op
  input  logic        in_tlast,  // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // answer[1:0]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [31:0] cfg_tdata  // gap_limit
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int QW = gcsg_pkg::QIDX_W;
  localparam int XW = (CW > QW) ? CW : QW;
  localparam int PW = gcsg_pkg::POS_W;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_SORT = 4'b0010,
    T_QA   = 4'b0100,
    T_QB   = 4'b1000
  } top_state_t;

  top_state_t    st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          grouped_r, grouped_nxt;
  logic [PW-1:0] gap_limit_r;
  logic [AW-1:0] b_r, b_nxt;
  logic          bad_r, bad_nxt;
  logic [AW-1:0] lab_a_r, lab_a_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    answer_r, answer_nxt;

  logic [PW-1:0] in_pos;
  logic [QW-1:0] in_ia, in_ib;
  logic          in_acc;
  logic [CW-1:0] base;
  logic          ld_we, start, done;
  logic          lbl_we;
  logic [AW-1:0] lbl_addr, lbl_data, lbl_raddr, lbl_rdata;

  assign in_pos     = in_tdata[31:0];
  assign in_ia      = in_tdata[41:32];
  assign in_ib      = in_tdata[51:42];
  assign in_tready  = (st_r == T_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, answer_r};
  assign base       = grouped_r ? '0 : count_r;

  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    grouped_nxt   = grouped_r;
    b_nxt         = b_r;
    bad_nxt       = bad_r;
    lab_a_nxt     = lab_a_r;
    out_valid_nxt = out_valid_r && !out_tready;
    answer_nxt    = answer_r;
    ld_we         = 1'b0;
    start         = 1'b0;
    lbl_raddr     = b_r;
    unique case (st_r)
      T_IDLE: begin
        lbl_raddr = AW'(in_ia);
        if (in_acc) begin
          if (in_tuser == gcsg_pkg::OP_LOAD) begin
            grouped_nxt = 1'b0;
            // A full store drops the position but still honors tlast.
            if (base != CW'(MAX_POINTS)) begin
              ld_we     = 1'b1;
              count_nxt = base + CW'(1);
            end else begin
              count_nxt = base;
            end
            if (in_tlast) begin
              start  = 1'b1;
              st_nxt = T_SORT;
            end
          end else begin
            b_nxt   = AW'(in_ib);
            bad_nxt = !grouped_r || (XW'(in_ia) >= XW'(count_r)) ||
                      (XW'(in_ib) >= XW'(count_r));
            st_nxt  = T_QA;
          end
        end
      end
      T_SORT: begin
        if (done) begin
          grouped_nxt = 1'b1;
          st_nxt      = T_IDLE;
        end
      end
      T_QA: begin
        lab_a_nxt = lbl_rdata;
        st_nxt    = T_QB;
      end
      T_QB: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            answer_nxt = gcsg_pkg::ANS_BAD;
          end else if (lab_a_r == lbl_rdata) begin
            answer_nxt = gcsg_pkg::ANS_SAME;
          end else begin
            answer_nxt = gcsg_pkg::ANS_DIFF;
          end
          st_nxt = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      count_r     <= '0;
      grouped_r   <= 1'b0;
      gap_limit_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      grouped_r   <= grouped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) begin
        gap_limit_r <= cfg_tdata;
      end
    end
    b_r      <= b_nxt;
    bad_r    <= bad_nxt;
    lab_a_r  <= lab_a_nxt;
    answer_r <= answer_nxt;
  end

  gcsg_sorter #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .CW    (CW)
  ) u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_we     (ld_we),
    .ld_addr   (base[AW-1:0]),
    .ld_pos    (in_pos),
    .start     (start),
    .count     (count_r),
    .gap_limit (gap_limit_r),
    .done      (done),
    .lbl_we    (lbl_we),
    .lbl_addr  (lbl_addr),
    .lbl_data  (lbl_data)
  );

  gcsg_label_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_label_mem (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (lbl_addr),
    .wdata (lbl_data),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  a_answer_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3))
    else $error("answer code out of range");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == gcsg_pkg::OP_QUERY) |=> !in_tready)
    else $error("query did not hold off the input");

  a_label_write_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    lbl_we |-> (st_r == T_SORT))
    else $error("label written outside the sort pass");

  a_done_grouped: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> grouped_r)
    else $error("sort pass end did not mark grouped");

endmodule
